/* rtl/gbi_pkg.sv */
// Package for the grid bilinear interpolator.
// Holds the item structs, the opcode and register index codes.
// Depends on nothing; the top level and its checker import it.
package gbi_pkg;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_ORIGIN    = 3'd0,
    CFG_X_SCALE     = 3'd1,
    CFG_Y_ORIGIN    = 3'd2,
    CFG_Y_SCALE     = 3'd3,
    CFG_COLS_IN_USE = 3'd4,
    CFG_ROWS_IN_USE = 3'd5
  } cfg_index_e;

  typedef struct packed {
    logic               opcode;
    logic        [7:0]  node_col;
    logic        [7:0]  node_row;
    logic signed [31:0] node_height;
    logic               node_undefined;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] height;
    logic               height_defined;
  } out_item_t;

endpackage

/* rtl/grid_bilinear_interpolator.sv */
// Top level of the grid bilinear interpolator: grid memory, query sequencer and blend datapath.
// Depends on gbi_pkg for the item structs and codes.
//
// A write transfer stores one node in the grid memory; it gives no result.
// A query is taken and then runs on its own: the two mapping multipliers, the range check,
// one read per node from the single-port grid memory (one node at the far corner, two on
// the last row or column, four elsewhere), the landing of the last read, two blend stages
// and the load of the result, which waits while an earlier result still waits for
// out_ready_i; a point outside the grid goes from the range check straight to the load.
// The next item is taken the cycle after the result is loaded into the output register,
// even while that result still waits for out_ready_i.
// The grid memory has no reset: a node must be written before a query uses it.
module grid_bilinear_interpolator
  import gbi_pkg::*;
#(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int IXW   = $clog2(MAX_COLS);
  localparam int IYW   = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);

  localparam logic signed [48:0] HALF16 = 49'sd32768;
  localparam logic signed [65:0] HALF32 = 66'sd2147483648;

  typedef enum logic [2:0] {
    S_IDLE, S_MAP, S_CHECK, S_READ, S_LAND, S_BL1, S_BL2, S_FIN
  } state_e;

  typedef enum logic [1:0] {
    SL_00, SL_10, SL_01, SL_11
  } slot_e;

  // Configuration registers
  logic [31:0] x_origin_q, x_scale_q, y_origin_q, y_scale_q;
  logic [8:0]  cols_in_use_q, rows_in_use_q;

  state_e      state_q, state_d;
  slot_e       slot_q, slot_d, cap_slot_q;
  logic        cap_vld_q;
  logic        out_valid_q;
  out_item_t   out_item_q;

  // Datapath registers
  logic signed [32:0] dx_q, dy_q;
  logic        [63:0] gx_q, gy_q;
  logic               negx_q, negy_q;
  logic               ok_q, undef_q, last_c_q, last_r_q;
  logic [IXW-1:0]     ix_q;
  logic [IYW-1:0]     iy_q;
  logic [15:0]        fx_q, fy_q;
  logic signed [31:0] h00_q, h10_q, h01_q, h11_q;
  logic signed [47:0] lo_q, hi_q;
  logic signed [64:0] prod2_q;

  // Grid memory: height in bits 31..0, undefined flag in bit 32
  logic [32:0] mem [DEPTH];
  logic [32:0] rdata_q;
  logic        mem_we, mem_re;
  logic [AW-1:0] waddr, raddr, base_addr;

  logic        in_acc, out_load, read_done;
  logic [CW-1:0] cols_eff;
  logic [RW-1:0] rows_eff;
  logic        ok_c, last_c_c, last_r_c;

  logic signed [32:0] diff_a, diff_b;
  logic signed [16:0] frac_a;
  logic signed [49:0] lo_full, hi_full;
  logic signed [48:0] dv;
  logic signed [65:0] v32, r32;
  logic signed [48:0] r16;
  logic signed [31:0] result_c;
  logic               defined_c;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_origin_q    <= 32'd0;
      x_scale_q     <= 32'd65536;
      y_origin_q    <= 32'd0;
      y_scale_q     <= 32'd65536;
      cols_in_use_q <= 9'd256;
      rows_in_use_q <= 9'd256;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_X_ORIGIN:    x_origin_q    <= cfg_data_i;
        CFG_X_SCALE:     x_scale_q     <= cfg_data_i;
        CFG_Y_ORIGIN:    y_origin_q    <= cfg_data_i;
        CFG_Y_SCALE:     y_scale_q     <= cfg_data_i;
        CFG_COLS_IN_USE: cols_in_use_q <= cfg_data_i[8:0];
        CFG_ROWS_IN_USE: rows_in_use_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // Grid size clamped to the range the memory supports
  always_comb begin
    if (cols_in_use_q < 9'd2) begin
      cols_eff = CW'(2);
    end else if (32'(cols_in_use_q) > 32'(MAX_COLS)) begin
      cols_eff = CW'(MAX_COLS);
    end else begin
      cols_eff = CW'(cols_in_use_q);
    end
    if (rows_in_use_q < 9'd2) begin
      rows_eff = RW'(2);
    end else if (32'(rows_in_use_q) > 32'(MAX_ROWS)) begin
      rows_eff = RW'(MAX_ROWS);
    end else begin
      rows_eff = RW'(rows_in_use_q);
    end
  end

  // Range check on the integer part of the grid coordinates
  assign ok_c = !negx_q && !negy_q &&
                (gx_q[63:32] < 32'(cols_eff)) && (gy_q[63:32] < 32'(rows_eff));
  assign last_c_c = (gx_q[63:32] == 32'(cols_eff) - 32'd1);
  assign last_r_c = (gy_q[63:32] == 32'(rows_eff) - 32'd1);

  // Read order over the neighbors that the case needs
  always_comb begin
    slot_d    = slot_q;
    read_done = 1'b0;
    unique case (slot_q)
      SL_00: begin
        if (last_c_q && last_r_q) begin
          read_done = 1'b1;
        end else if (last_c_q) begin
          slot_d = SL_01;
        end else begin
          slot_d = SL_10;
        end
      end
      SL_10: begin
        if (last_r_q) begin
          read_done = 1'b1;
        end else begin
          slot_d = SL_01;
        end
      end
      SL_01: begin
        if (last_c_q) begin
          read_done = 1'b1;
        end else begin
          slot_d = SL_11;
        end
      end
      SL_11: read_done = 1'b1;
      default: read_done = 1'b1;
    endcase
  end

  assign base_addr = AW'(iy_q) * AW'(MAX_COLS) + AW'(ix_q);

  always_comb begin
    case (slot_q)
      SL_10:   raddr = base_addr + AW'(1);
      SL_01:   raddr = base_addr + AW'(MAX_COLS);
      SL_11:   raddr = base_addr + AW'(MAX_COLS + 1);
      default: raddr = base_addr;
    endcase
  end

  assign mem_re = (state_q == S_READ);
  assign mem_we = in_acc && (in_item_i.opcode == OP_WRITE) &&
                  (32'(in_item_i.node_col) < 32'(MAX_COLS)) &&
                  (32'(in_item_i.node_row) < 32'(MAX_ROWS));
  assign waddr  = AW'(in_item_i.node_row) * AW'(MAX_COLS) + AW'(in_item_i.node_col);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= {in_item_i.node_undefined, in_item_i.node_height};
    end
    if (mem_re) begin
      rdata_q <= mem[raddr];
    end
  end

  // Blend arithmetic: a*(1-f) + b*f written as a*2^16 + (b-a)*f
  always_comb begin
    if (last_c_q) begin
      diff_a = 33'(h01_q) - 33'(h00_q);
      frac_a = $signed({1'b0, fy_q});
    end else begin
      diff_a = 33'(h10_q) - 33'(h00_q);
      frac_a = $signed({1'b0, fx_q});
    end
    diff_b  = 33'(h11_q) - 33'(h01_q);
    lo_full = (50'(h00_q) <<< 16) + diff_a * frac_a;
    hi_full = (50'(h01_q) <<< 16) + diff_b * $signed({1'b0, fx_q});
    dv      = 49'(hi_q) - 49'(lo_q);
    v32     = (66'(lo_q) <<< 16) + 66'(prod2_q);
    r32     = v32 + HALF32;
    r16     = 49'(lo_q) + HALF16;
    if (last_c_q && last_r_q) begin
      result_c = h00_q;
    end else if (last_c_q || last_r_q) begin
      result_c = r16[47:16];
    end else begin
      result_c = r32[63:32];
    end
    defined_c = ok_q && !undef_q;
  end

  assign out_load = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc && (in_item_i.opcode == OP_QUERY)) state_d = S_MAP;
      S_MAP:   state_d = S_CHECK;
      S_CHECK: state_d = ok_c ? S_READ : S_FIN;
      S_READ:  if (read_done) state_d = S_LAND;
      S_LAND:  state_d = S_BL1;
      S_BL1:   state_d = S_BL2;
      S_BL2:   state_d = S_FIN;
      S_FIN:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer state and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slot_q      <= SL_00;
      cap_slot_q  <= SL_00;
      cap_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      state_q    <= state_d;
      cap_vld_q  <= mem_re;
      cap_slot_q <= slot_q;
      if (state_q == S_CHECK) begin
        slot_q <= SL_00;
      end else if (state_q == S_READ) begin
        slot_q <= slot_d;
      end
      if (out_load) begin
        out_valid_q               <= 1'b1;
        out_item_q.height         <= defined_c ? result_c : 32'sd0;
        out_item_q.height_defined <= defined_c;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers, loaded by the sequencer
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dx_q <= 33'($signed(in_item_i.point_x)) - 33'($signed(x_origin_q));
      dy_q <= 33'($signed(in_item_i.point_y)) - 33'($signed(y_origin_q));
    end
    if (state_q == S_MAP) begin
      // A zero scale maps every point to index 0, whatever its side of the origin.
      gx_q   <= (x_scale_q == 32'd0) ? 64'd0 : 64'(dx_q[31:0]) * 64'(x_scale_q);
      gy_q   <= (y_scale_q == 32'd0) ? 64'd0 : 64'(dy_q[31:0]) * 64'(y_scale_q);
      negx_q <= (x_scale_q != 32'd0) && dx_q[32];
      negy_q <= (y_scale_q != 32'd0) && dy_q[32];
    end
    if (state_q == S_CHECK) begin
      ok_q     <= ok_c;
      undef_q  <= 1'b0;
      last_c_q <= last_c_c;
      last_r_q <= last_r_c;
      ix_q     <= gx_q[32 +: IXW];
      iy_q     <= gy_q[32 +: IYW];
      fx_q     <= gx_q[31:16];
      fy_q     <= gy_q[31:16];
    end
    if (cap_vld_q) begin
      undef_q <= undef_q | rdata_q[32];
      case (cap_slot_q)
        SL_00:   h00_q <= rdata_q[31:0];
        SL_10:   h10_q <= rdata_q[31:0];
        SL_01:   h01_q <= rdata_q[31:0];
        default: h11_q <= rdata_q[31:0];
      endcase
    end
    if (state_q == S_BL1) begin
      lo_q <= 48'(lo_full);
      hi_q <= 48'(hi_full);
    end
    if (state_q == S_BL2) begin
      prod2_q <= 65'(dv) * 65'($signed({1'b0, fy_q}));
    end
  end

endmodule

/* rtl/gbi_checker.sv */
// Port-level checker for the grid bilinear interpolator, with its bind statement.
// Depends on gbi_pkg for the item structs and opcodes.
module gbi_checker
  import gbi_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input in_item_t             in_item_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input out_item_t            out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before its transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_item_o))
    else $error("stalled result changed");

  a_undef_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.height_defined |-> out_item_o.height == 32'sd0)
    else $error("undefined result with nonzero height");

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_item_i.opcode == OP_WRITE) && !out_valid_o
    |=> !out_valid_o)
    else $error("node write produced a result");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_item_i.opcode == OP_QUERY) |=> !in_ready_o)
    else $error("input taken while a query is in progress");

endmodule

bind grid_bilinear_interpolator gbi_checker u_gbi_checker (.*);
